// File: rtl/pfsa_pkg.sv
`default_nettype none

package pfsa_pkg;

    // Geometry of the page pool.
    localparam int NUM_PAGES  = 64;
    localparam int PAGE_BYTES = 256;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int BYTE_W     = $clog2(PAGE_BYTES);
    localparam int STORE_AW   = PAGE_W + BYTE_W;

    // Field widths of the transactions.
    localparam int CNT_W  = 7;
    localparam int OFF_W  = 9;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_OUT_OF_MEMORY = 3'd1,
        ST_OUT_OF_RANGE  = 3'd2,
        ST_NOT_ALLOCATED = 3'd3,
        ST_FREE_IGNORED  = 3'd4,
        ST_ZERO_COUNT    = 3'd5
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE_RD,
        S_POP,
        S_CLEAR,
        S_RESP
    } state_e;

    typedef struct packed {
        cmd_e              cmd;
        logic [CNT_W-1:0]  count;
        logic [5:0]        page;
        logic [OFF_W-1:0]  offset;
        logic              byte_count;
        logic [DATA_W-1:0] write_data;
    } in_t;

    typedef struct packed {
        status_e           status;
        logic [5:0]        alloc_page;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  free_count;
        logic              last;
    } out_t;

    // Request bundle for the page byte store.
    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [DATA_W-1:0]   wdata;
        logic [STORE_AW-1:0] raddr;
    } store_req_t;

    // Request bundle for the free stack.
    typedef struct packed {
        logic              reinit;
        logic              push;
        logic [PAGE_W-1:0] push_addr;
        logic [PAGE_W-1:0] push_page;
        logic [PAGE_W-1:0] rd_addr;
        logic [CNT_W-1:0]  total;
    } stack_req_t;

endpackage

`default_nettype wire

// File: rtl/page_free_stack_allocator_top.sv
`default_nettype none

// Page allocator over a LIFO free stack, with one allocated bit per page and a
// byte store of 64 pages of 256 bytes. A free, a zero-count or failed allocate,
// a rejected access and a byte write pass from the result register through
// S_RESP into the output register; a byte read first passes through S_BYTE_RD,
// because the byte store has a registered read. A successful allocate passes
// through S_POP, S_CLEAR and S_RESP for each page: each popped page is zeroed
// one byte per cycle through the single write port of the byte store.
// A result that finds the output register still full waits there, and an
// allocate pops no further page until the result of the previous one has moved on.
// One transaction is worked on at a time, and the next one is accepted while
// the last result still waits in the output register. After reset or a write
// to total_pages every page is free with page 0 on top, at once and without a
// clearing pass; a page's bytes read as zero after it is allocated.
module page_free_stack_allocator_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pfsa_pkg::CNT_W-1:0]  cfg_data,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire pfsa_pkg::in_t               req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output pfsa_pkg::out_t                   rsp
);
    import pfsa_pkg::*;

    state_e               state_reg;
    state_e               state_next;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     total_next;
    logic [CNT_W-1:0]     depth_reg;
    logic [CNT_W-1:0]     depth_next;
    logic [NUM_PAGES-1:0] alloc_reg;
    logic [NUM_PAGES-1:0] alloc_next;
    logic [CNT_W-1:0]     left_reg;
    logic [CNT_W-1:0]     left_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic [PAGE_W-1:0]    page_reg;
    logic [PAGE_W-1:0]    page_next;
    logic [BYTE_W-1:0]    clr_reg;
    logic [BYTE_W-1:0]    clr_next;
    out_t                 res_reg;
    out_t                 res_next;
    out_t                 rsp_reg;
    out_t                 rsp_next;

    logic                 req_fire;
    logic                 cfg_fire;
    logic                 rsp_free;
    logic                 page_in_range;
    logic                 page_alloc;
    logic                 access_range;
    logic                 free_ok;
    logic                 alloc_ok;
    logic                 byte_rd;
    logic                 byte_wr;
    logic [CNT_W-1:0]     total_clamped;
    logic [PAGE_W-1:0]    top_page;
    logic [DATA_W-1:0]    store_rd_data;
    store_req_t           store_req;
    stack_req_t           stack_req;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign req_fire  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Register value limited to the pool size, and zero taken as one.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            total_clamped = CNT_W'(1);
        end
        else if (cfg_data > CNT_W'(NUM_PAGES))
        begin
            total_clamped = CNT_W'(NUM_PAGES);
        end
        else
        begin
            total_clamped = cfg_data;
        end
    end

    // Checks on the incoming transaction.
    assign page_in_range = {1'b0, req.page} < total_reg;
    assign page_alloc    = alloc_reg[req.page];
    assign access_range  = !page_in_range || (req.offset > OFF_W'(PAGE_BYTES))
                           || (req.byte_count && (req.offset == OFF_W'(PAGE_BYTES)));
    assign free_ok       = page_in_range && page_alloc && (depth_reg < CNT_W'(NUM_PAGES));
    assign alloc_ok      = (req.count != '0) && (req.count <= depth_reg);
    assign byte_rd       = (req.cmd == CMD_READ) && !access_range && page_alloc
                           && req.byte_count;
    assign byte_wr       = (req.cmd == CMD_WRITE) && !access_range && page_alloc
                           && req.byte_count;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if ((req.cmd == CMD_ALLOC) && alloc_ok)
                    begin
                        state_next = S_POP;
                    end
                    else if (byte_rd)
                    begin
                        state_next = S_BYTE_RD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_BYTE_RD:
            begin
                state_next = S_RESP;
            end
            S_POP:
            begin
                state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = (left_reg > CNT_W'(1)) ? S_POP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, state updates and memory requests.
    always_comb
    begin
        total_next     = total_reg;
        depth_next     = depth_reg;
        alloc_next     = alloc_reg;
        left_next      = left_reg;
        page_next      = page_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        stack_req.reinit    = 1'b0;
        stack_req.push      = 1'b0;
        stack_req.push_addr = depth_reg[PAGE_W-1:0];
        stack_req.push_page = req.page;
        stack_req.rd_addr   = PAGE_W'(depth_reg - CNT_W'(1));
        stack_req.total     = total_reg;

        store_req.we    = 1'b0;
        store_req.waddr = {req.page, req.offset[BYTE_W-1:0]};
        store_req.wdata = req.write_data;
        store_req.raddr = {req.page, req.offset[BYTE_W-1:0]};

        // Decode an accepted transaction.
        if ((state_reg == S_IDLE) && req_fire)
        begin
            res_next.status     = ST_OK;
            res_next.alloc_page = '0;
            res_next.read_data  = '0;
            res_next.free_count = depth_reg;
            res_next.last       = 1'b1;
            left_next           = '0;
            if (req.cmd == CMD_ALLOC)
            begin
                if (req.count == '0)
                begin
                    res_next.status = ST_ZERO_COUNT;
                end
                else if (!alloc_ok)
                begin
                    res_next.status = ST_OUT_OF_MEMORY;
                end
                else
                begin
                    left_next           = req.count;
                    res_next.free_count = depth_reg - req.count;
                end
            end
            else if (req.cmd == CMD_FREE)
            begin
                if (free_ok)
                begin
                    alloc_next[req.page] = 1'b0;
                    depth_next           = depth_reg + CNT_W'(1);
                    stack_req.push       = 1'b1;
                    res_next.free_count  = depth_reg + CNT_W'(1);
                end
                else
                begin
                    res_next.status = ST_FREE_IGNORED;
                end
            end
            else if (access_range)
            begin
                res_next.status = ST_OUT_OF_RANGE;
            end
            else if (!page_alloc)
            begin
                res_next.status = ST_NOT_ALLOCATED;
            end
            else
            begin
                store_req.we = byte_wr;
            end
        end

        // Byte read data arrives in the cycle after the address.
        if (state_reg == S_BYTE_RD)
        begin
            res_next.read_data = store_rd_data;
        end

        // Take the top of the stack and mark the page allocated.
        if (state_reg == S_POP)
        begin
            alloc_next[top_page] = 1'b1;
            depth_next           = depth_reg - CNT_W'(1);
            page_next            = top_page;
            clr_next             = '0;
        end

        // Zero the page one byte per cycle.
        if (state_reg == S_CLEAR)
        begin
            store_req.we    = 1'b1;
            store_req.waddr = {page_reg, clr_reg};
            store_req.wdata = '0;
            clr_next        = clr_reg + BYTE_W'(1);
            if (clr_reg == '1)
            begin
                res_next.status     = ST_OK;
                res_next.alloc_page = page_reg;
                res_next.read_data  = '0;
                res_next.last       = (left_reg == CNT_W'(1));
            end
        end

        // Output register: load a result or drain the one taken.
        if ((state_reg == S_RESP) && rsp_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res_reg;
            if (left_reg > CNT_W'(1))
            begin
                left_next = left_reg - CNT_W'(1);
            end
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // A register write puts every page back on the free stack.
        if (cfg_fire)
        begin
            total_next       = total_clamped;
            depth_next       = total_clamped;
            alloc_next       = '0;
            stack_req.reinit = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= CNT_W'(NUM_PAGES);
            depth_reg     <= CNT_W'(NUM_PAGES);
            alloc_reg     <= '0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            depth_reg     <= depth_next;
            alloc_reg     <= alloc_next;
            left_reg      <= left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        clr_reg  <= clr_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    pfsa_free_stack u_free_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (stack_req),
        .top_page (top_page)
    );

    pfsa_page_store u_page_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (store_rd_data)
    );

endmodule

`default_nettype wire

// File: rtl/pfsa_page_store.sv
`default_nettype none

module pfsa_page_store (
    input  wire logic                        clk,
    input  wire pfsa_pkg::store_req_t        req,
    output logic [pfsa_pkg::DATA_W-1:0]      rd_data
);
    import pfsa_pkg::*;

    logic [DATA_W-1:0] mem [NUM_PAGES*PAGE_BYTES];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/pfsa_free_stack.sv
`default_nettype none

module pfsa_free_stack (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pfsa_pkg::stack_req_t        req,
    output logic [pfsa_pkg::PAGE_W-1:0]      top_page
);
    import pfsa_pkg::*;

    logic [PAGE_W-1:0]    mem [NUM_PAGES];
    logic [PAGE_W-1:0]    rd_data_reg;
    logic [PAGE_W-1:0]    rd_addr_reg;
    logic                 rd_valid_reg;
    logic [NUM_PAGES-1:0] valid_reg;
    logic [NUM_PAGES-1:0] valid_next;
    logic [CNT_W-1:0]     reset_value;

    // An entry never pushed since the last reinit holds total - 1 - index.
    always_comb
    begin
        valid_next = valid_reg;
        if (req.reinit)
        begin
            valid_next = '0;
        end
        else if (req.push)
        begin
            valid_next[req.push_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stack memory with a registered read of the top entry.
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[req.push_addr] <= req.push_page;
        end
        rd_data_reg  <= mem[req.rd_addr];
        rd_addr_reg  <= req.rd_addr;
        rd_valid_reg <= valid_reg[req.rd_addr];
    end

    // Substitute the initial contents for entries that were never written.
    assign reset_value = req.total - CNT_W'(1) - {1'b0, rd_addr_reg};
    assign top_page    = rd_valid_reg ? rd_data_reg : reset_value[PAGE_W-1:0];

endmodule

`default_nettype wire

// File: bench/page_free_stack_allocator_checker.sv
`default_nettype none

module page_free_stack_allocator_checker
    import pfsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             req_valid,
    input  wire logic             req_ready,
    input  wire in_t              req,
    input  wire logic             rsp_valid,
    input  wire logic             rsp_ready,
    input  wire out_t             rsp,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the allocator state.
    int unsigned       pages_in_use;
    logic [PAGE_W-1:0] free_stack [NUM_PAGES];
    int unsigned       free_depth;
    logic              page_taken [NUM_PAGES];
    logic [DATA_W-1:0] page_mem [NUM_PAGES*PAGE_BYTES];

    // Results still owed by the block, oldest first.
    out_t expected_results [$];
    int   fail_total;

    // A write to total_pages clamps the value and puts every page back on the stack.
    function automatic void restock_pages(input logic [CNT_W-1:0] value);
        int unsigned n;
        int i;
        n = value;
        if (n < 1)
            n = 1;
        if (n > NUM_PAGES)
            n = NUM_PAGES;
        pages_in_use = n;
        free_depth = n;
        for (i = 0; i < NUM_PAGES; i++)
        begin
            free_stack[i] = (i < n) ? PAGE_W'(n - 1 - i) : '0;
            page_taken[i] = 1'b0;
        end
    endfunction

    // Every result reports the free pages left once the whole transaction is done.
    function automatic void queue_result(input status_e st, input logic [PAGE_W-1:0] pg,
                                         input logic [DATA_W-1:0] data, input logic fin);
        out_t r;
        r.status = st;
        r.alloc_page = pg;
        r.read_data = data;
        r.free_count = CNT_W'(free_depth);
        r.last = fin;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Applies one request transaction to the shadow state and queues its results.
    function automatic void predict_command(input in_t t);
        logic [PAGE_W-1:0] handed [NUM_PAGES];
        logic [DATA_W-1:0] rd;
        int unsigned n;
        int unsigned addr;
        int i;
        int b;
        rd = '0;
        if (t.cmd == CMD_ALLOC)
        begin
            n = t.count;
            if (n == 0)
                queue_result(ST_ZERO_COUNT, '0, '0, 1'b1);
            else if (n > free_depth)
                queue_result(ST_OUT_OF_MEMORY, '0, '0, 1'b1);
            else
            begin
                // Pop from the top and clear each page before anything is reported.
                for (i = 0; i < n; i++)
                begin
                    free_depth--;
                    handed[i] = free_stack[free_depth];
                    page_taken[handed[i]] = 1'b1;
                    for (b = 0; b < PAGE_BYTES; b++)
                        page_mem[int'(handed[i]) * PAGE_BYTES + b] = '0;
                end
                for (i = 0; i < n; i++)
                    queue_result(ST_OK, handed[i], '0, (i == n - 1));
            end
        end
        else if (t.cmd == CMD_FREE)
        begin
            if (t.page < pages_in_use && page_taken[t.page] && free_depth < NUM_PAGES)
            begin
                page_taken[t.page] = 1'b0;
                free_stack[free_depth] = t.page;
                free_depth++;
                queue_result(ST_OK, '0, '0, 1'b1);
            end
            else
                queue_result(ST_FREE_IGNORED, '0, '0, 1'b1);
        end
        else if (t.page >= pages_in_use || int'(t.offset) > PAGE_BYTES ||
                 int'(t.byte_count) > PAGE_BYTES - int'(t.offset))
            queue_result(ST_OUT_OF_RANGE, '0, '0, 1'b1);
        else if (!page_taken[t.page])
            queue_result(ST_NOT_ALLOCATED, '0, '0, 1'b1);
        else
        begin
            // A zero-byte access only checks bounds and allocation.
            if (t.byte_count)
            begin
                addr = int'(t.page) * PAGE_BYTES + int'(t.offset);
                if (t.cmd == CMD_WRITE)
                    page_mem[addr] = t.write_data;
                else
                    rd = page_mem[addr];
            end
            queue_result(ST_OK, '0, rd, 1'b1);
        end
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_total++;
        end
    endfunction

    // Watch the three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        int a;
        if (!rst_n)
        begin
            restock_pages(CNT_W'(NUM_PAGES));
            for (a = 0; a < NUM_PAGES * PAGE_BYTES; a++)
                page_mem[a] = '0;
            expected_results.delete();
            fail_total = 0;
        end
        else
        begin
            // Results belong to earlier transactions, so compare them first.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d, page %0d",
                           rsp.status, rsp.alloc_page);
                    fail_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("alloc_page", want.alloc_page, rsp.alloc_page);
                    check_field("read_data", want.read_data, rsp.read_data);
                    check_field("free_count", want.free_count, rsp.free_count);
                    check_field("last", want.last, rsp.last);
                end
            end
            if (cfg_valid && cfg_ready)
                restock_pages(cfg_data);
            if (req_valid && req_ready)
                predict_command(req);
        end
        mismatches <= fail_total;
        outstanding <= expected_results.size();
    end

endmodule

`default_nettype wire

// File: bench/page_free_stack_allocator_top_test.sv
`default_nettype none

module page_free_stack_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfsa_pkg::*;

    // An allocate hands out one result per page.
    localparam int QUIET_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 30;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    in_t              req       = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    out_t             rsp;

    int          mismatches;
    int          outstanding;
    int          send_gap_pct  = 29;
    int          rsp_stall_pct = 74;
    int unsigned page_limit    = NUM_PAGES;
    int unsigned free_hint     = NUM_PAGES;
    int          quiet_cycles  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    page_free_stack_allocator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    page_free_stack_allocator_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Random back-pressure on the result channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // The last reported free count steers the size of new allocations.
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            free_hint <= rsp.free_count;
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (req_valid && req_ready) ||
            (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic in_t make_cmd(input cmd_e op, input int unsigned cnt,
                                     input int unsigned pg, input int unsigned off,
                                     input int unsigned nb, input int unsigned data);
        in_t t;
        t.cmd = op;
        t.count = CNT_W'(cnt);
        t.page = 6'(pg);
        t.offset = OFF_W'(off);
        t.byte_count = nb[0];
        t.write_data = DATA_W'(data);
        return t;
    endfunction

    // Mostly low pages, which the LIFO order keeps allocated most of the time.
    function automatic int unsigned pick_page();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return $urandom_range(0, NUM_PAGES - 1);
        if (roll < 30)
            return $urandom_range(0, page_limit - 1);
        return $urandom_range(0, ((page_limit > 8) ? 8 : page_limit) - 1);
    endfunction

    // One random request: mostly well-formed, a few fully random ones.
    function automatic in_t random_command();
        in_t t;
        int unsigned roll;
        int unsigned kind;
        int unsigned cap;
        t = make_cmd(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 127),
                     $urandom_range(0, 63), $urandom_range(0, 511),
                     $urandom_range(0, 1), $urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return t;
        if (roll < 30)
        begin
            t.cmd = CMD_ALLOC;
            kind = $urandom_range(0, 19);
            cap = (free_hint > 4) ? 4 : ((free_hint == 0) ? 1 : free_hint);
            if (kind == 0)
                t.count = '0;
            else if (kind == 1)
                t.count = CNT_W'(free_hint + $urandom_range(1, 3));
            else if (kind == 2 && free_hint > 0)
                t.count = CNT_W'($urandom_range(1, free_hint));
            else
                t.count = CNT_W'($urandom_range(1, cap));
        end
        else if (roll < 50)
        begin
            t.cmd = CMD_FREE;
            t.page = 6'(pick_page());
        end
        else
        begin
            t.cmd = (roll < 75) ? CMD_WRITE : CMD_READ;
            t.page = 6'(pick_page());
            kind = $urandom_range(0, 99);
            if (kind < 80)
                t.offset = OFF_W'($urandom_range(0, 7));
            else if (kind < 95)
                t.offset = OFF_W'($urandom_range(0, PAGE_BYTES - 1));
            else
                t.offset = OFF_W'($urandom_range(PAGE_BYTES, 511));
            t.byte_count = ($urandom_range(0, 9) != 0);
        end
        return t;
    endfunction

    // Present one request transaction, with an optional gap before it.
    task automatic send_command(input in_t item);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_gap_pct);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write total_pages once the block has gone idle.
    task automatic set_total_pages(input logic [CNT_W-1:0] value);
        drain_results();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value == 0)
            page_limit = 1;
        else if (value > NUM_PAGES)
            page_limit = NUM_PAGES;
        else
            page_limit = value;
    endtask

    initial
    begin
        logic [CNT_W-1:0] page_settings [6];
        page_settings = '{7'd0, 7'd127, 7'd3, CNT_W'($urandom_range(2, 63)), 7'd1, 7'd64};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset setting of 64 pages.
        send_command(make_cmd(CMD_READ, 0, 0, 0, 1, 0));
        send_command(make_cmd(CMD_FREE, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_ALLOC, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_ALLOC, 127, 63, 511, 1, 255));
        send_command(make_cmd(CMD_ALLOC, NUM_PAGES + 1, 0, 0, 0, 0));
        send_command(make_cmd(CMD_ALLOC, NUM_PAGES, 0, 0, 0, 0));
        send_command(make_cmd(CMD_ALLOC, 1, 0, 0, 0, 0));
        send_command(make_cmd(CMD_WRITE, 0, 63, PAGE_BYTES - 1, 1, 8'hFF));
        send_command(make_cmd(CMD_READ, 0, 63, PAGE_BYTES - 1, 1, 0));
        send_command(make_cmd(CMD_READ, 0, 63, 0, 1, 0));
        send_command(make_cmd(CMD_WRITE, 0, 0, PAGE_BYTES, 1, 8'h55));
        send_command(make_cmd(CMD_WRITE, 0, 0, PAGE_BYTES, 0, 8'h55));
        send_command(make_cmd(CMD_READ, 0, 0, 511, 0, 0));
        send_command(make_cmd(CMD_WRITE, 0, 5, 0, 0, 8'hAA));
        send_command(make_cmd(CMD_WRITE, 0, 5, 0, 1, 8'hA5));
        send_command(make_cmd(CMD_READ, 0, 5, 0, 1, 0));
        send_command(make_cmd(CMD_FREE, 0, 5, 0, 0, 0));
        send_command(make_cmd(CMD_FREE, 0, 5, 0, 0, 0));
        send_command(make_cmd(CMD_READ, 0, 5, 0, 1, 0));
        send_command(make_cmd(CMD_ALLOC, 1, 0, 0, 0, 0));
        send_command(make_cmd(CMD_READ, 0, 5, 0, 1, 0));
        send_command(make_cmd(CMD_FREE, 0, 63, 0, 0, 0));

        // Random phases, each after its own total_pages write; the idle pattern changes at phases 2 and 4.
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
            begin
                send_gap_pct = 74;
                rsp_stall_pct = 29;
            end
            else if (phase == 4)
            begin
                send_gap_pct = 0;
                rsp_stall_pct = 0;
            end
            set_total_pages(page_settings[phase]);
            repeat (RANDOM_PER_PHASE)
                send_command(random_command());
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/pfsa_pkg.sv
rtl/pfsa_page_store.sv
rtl/pfsa_free_stack.sv
rtl/page_free_stack_allocator_top.sv
bench/page_free_stack_allocator_checker.sv
bench/page_free_stack_allocator_top_test.sv
